// ===== design/gdcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// gdcsg_pkg: shared types and constants for the DVFS core scaling governor
// Register map, operation and mode codes, load thresholds and step table.
// ----------------------------------------------------------------------------
package gdcsg_pkg;

  typedef enum logic [1:0] {
    MODE_CORE_ONLY  = 2'd0,
    MODE_FREQ_CORES = 2'd1,
    MODE_DISABLED   = 2'd2,
    MODE_TURBO      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_PREHEAT = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    REG_GOV_MODE     = 3'd0,
    REG_MIN_STEP     = 3'd1,
    REG_MAX_STEP     = 3'd2,
    REG_TURBO_STEP   = 3'd3,
    REG_FIXED_STEP   = 3'd4,
    REG_MIN_CORES    = 3'd5,
    REG_TOTAL_CORES  = 3'd6,
    REG_INITIAL_STEP = 3'd7
  } reg_idx_t;

  typedef struct packed {
    mode_t       gov_mode;
    logic [2:0]  min_step;
    logic [2:0]  max_step;
    logic [2:0]  turbo_step;
    logic [2:0]  fixed_step;
    logic [3:0]  min_cores;
    logic [3:0]  total_cores;
  } cfg_t;

  typedef struct packed {
    logic [2:0] cur_step;
    logic [2:0] applied_step;
    logic [3:0] cores;
  } gov_state_t;

  typedef struct packed {
    logic [2:0] step;
    logic [2:0] freq_level;
    logic [3:0] cores_enabled;
    logic       apply_request;
  } result_t;

  // Register reset values
  localparam mode_t      RstGovMode     = MODE_FREQ_CORES;
  localparam logic [2:0] RstMinStep     = 3'd0;
  localparam logic [2:0] RstMaxStep     = 3'd3;
  localparam logic [2:0] RstTurboStep   = 3'd4;
  localparam logic [2:0] RstFixedStep   = 3'd3;
  localparam logic [3:0] RstMinCores    = 4'd1;
  localparam logic [3:0] RstTotalCores  = 4'd6;
  localparam logic [2:0] RstInitialStep = 3'd3;

  // Load thresholds (256 = fully busy)
  localparam logic [7:0] FastUpLimit  = 8'd205;
  localparam logic [7:0] PpAllCoresFs = 8'd205;
  localparam logic [7:0] PpDropFs     = 8'd77;
  localparam logic [7:0] PpAllCores   = 8'd230;
  localparam logic [7:0] PpOneMore    = 8'd128;
  localparam logic [7:0] PpHold       = 8'd102;

  // Rows of the step table; steps at or past this read all zeros
  localparam int TableEntries = 6;

  function automatic logic [2:0] row_freq(input logic [2:0] s);
    logic [2:0] f;
    f = 3'd0;
    if (int'(s) < TableEntries) begin
      case (s)
        3'd1:    f = 3'd1;
        3'd2:    f = 3'd2;
        3'd3:    f = 3'd3;
        3'd4:    f = 3'd4;
        default: f = 3'd0;
      endcase
    end
    return f;
  endfunction

  function automatic logic [8:0] row_down(input logic [2:0] s);
    logic [8:0] d;
    d = 9'd0;
    if (int'(s) < TableEntries) begin
      case (s)
        3'd1:    d = 9'd152;
        3'd2:    d = 9'd180;
        3'd3:    d = 9'd205;
        3'd4:    d = 9'd230;
        default: d = 9'd0;
      endcase
    end
    return d;
  endfunction

  function automatic logic [8:0] row_up(input logic [2:0] s);
    logic [8:0] u;
    u = 9'd0;
    if (int'(s) < TableEntries) begin
      case (s)
        3'd0:    u = 9'd200;
        3'd1:    u = 9'd205;
        3'd2:    u = 9'd212;
        3'd3:    u = 9'd236;
        3'd4:    u = 9'd256;
        default: u = 9'd0;
      endcase
    end
    return u;
  endfunction

endpackage

// ===== design/gdcsg_regs.sv =====
// ----------------------------------------------------------------------------
// gdcsg_regs: configuration register file
// Write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
module gdcsg_regs import gdcsg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [3:0] cfg_data,
  output cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gov_mode     <= RstGovMode;
      cfg.min_step     <= RstMinStep;
      cfg.max_step     <= RstMaxStep;
      cfg.turbo_step   <= RstTurboStep;
      cfg.fixed_step   <= RstFixedStep;
      cfg.min_cores    <= RstMinCores;
      cfg.total_cores  <= RstTotalCores;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_GOV_MODE:     cfg.gov_mode     <= mode_t'(cfg_data[1:0]);
        REG_MIN_STEP:     cfg.min_step     <= cfg_data[2:0];
        REG_MAX_STEP:     cfg.max_step     <= cfg_data[2:0];
        REG_TURBO_STEP:   cfg.turbo_step   <= cfg_data[2:0];
        REG_FIXED_STEP:   cfg.fixed_step   <= cfg_data[2:0];
        REG_MIN_CORES:    cfg.min_cores    <= cfg_data;
        REG_TOTAL_CORES:  cfg.total_cores  <= cfg_data;
        // initial step only acts at reset, where its reset value applies
        REG_INITIAL_STEP: ;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/gdcsg_core.sv =====
// ----------------------------------------------------------------------------
// gdcsg_core: governor decision logic
// Next step, core count and apply flag for one item, from current state.
// ----------------------------------------------------------------------------
module gdcsg_core import gdcsg_pkg::*; (
  input  cfg_t       cfg,
  input  gov_state_t cur,
  input  logic [1:0] operation,
  input  logic [7:0] gpu_load,
  input  logic [7:0] pp_load,
  output gov_state_t nxt,
  output result_t    res
);

  logic can_add;
  logic can_drop;
  logic apply;

  assign can_add  = cur.cores < cfg.total_cores;
  assign can_drop = cfg.min_cores < cur.cores;

  always_comb begin
    nxt   = cur;
    apply = 1'b0;
    case (op_t'(operation))
      OP_SAMPLE: begin
        case (cfg.gov_mode)
          MODE_FREQ_CORES: begin
            if ({1'b0, gpu_load} >= row_up(cur.cur_step)) begin
              if (gpu_load < FastUpLimit && cur.cur_step < cfg.max_step) begin
                nxt.cur_step = cur.cur_step + 3'd1;
              end else begin
                nxt.cur_step = cfg.max_step;
              end
              if (can_add) begin
                nxt.cores = (pp_load > PpAllCoresFs) ? cfg.total_cores
                                                     : cur.cores + 4'd1;
              end
            end else if ({1'b0, gpu_load} < row_down(cur.cur_step) &&
                         cur.cur_step > cfg.min_step) begin
              nxt.cur_step = cur.cur_step - 3'd1;
            end else if (pp_load < PpDropFs && can_drop) begin
              nxt.cores = cur.cores - 4'd1;
            end
            apply = (nxt.cores != cfg.total_cores) ||
                    (row_freq(nxt.cur_step) != row_freq(cur.applied_step));
          end
          MODE_CORE_ONLY: begin
            nxt.cur_step = cfg.fixed_step;
            if (pp_load > PpAllCores) begin
              if (can_add) begin
                nxt.cores = cfg.total_cores;
                apply     = 1'b1;
              end
            end else if (pp_load > PpOneMore) begin
              if (can_add) begin
                nxt.cores = cur.cores + 4'd1;
                apply     = 1'b1;
              end
            end else if (pp_load > PpHold) begin
              apply = 1'b0;
            end else if (pp_load != 8'd0 && can_drop) begin
              nxt.cores = cur.cores - 4'd1;
              apply     = 1'b1;
            end
          end
          default: ;
        endcase
      end
      OP_PREHEAT: begin
        if (can_add) begin
          nxt.cores = cfg.total_cores;
          apply     = 1'b1;
        end
      end
      OP_RESTART: begin
        nxt.cur_step = (cfg.gov_mode == MODE_TURBO) ? cfg.turbo_step : cfg.max_step;
        if (can_add) begin
          nxt.cores = cfg.total_cores;
        end
        apply = 1'b1;
      end
      default: ;
    endcase
    // clock is only re-applied when the table index really moves
    if (apply && row_freq(nxt.cur_step) != row_freq(cur.applied_step)) begin
      nxt.applied_step = nxt.cur_step;
    end
  end

  assign res.step          = nxt.cur_step;
  assign res.freq_level    = row_freq(nxt.cur_step);
  assign res.cores_enabled = nxt.cores;
  assign res.apply_request = apply;

endmodule

// ===== design/gpu_dvfs_core_scaling_governor.sv =====
// ----------------------------------------------------------------------------
// gpu_dvfs_core_scaling_governor: utilization-threshold DVFS governor
// Input register, single-pass decision logic, state and result registers.
// ----------------------------------------------------------------------------
// Each transfer on the input side (load sample, preheat or restart) yields
// exactly one result, held in the input register until the result register
// takes it while the output side is not stalled. The block sustains one
// item per cycle while results are taken: each decision is one pass of
// compare logic between the input register and the result register, and
// the governor state is updated in the same edge the result is loaded, so
// the next item already sees it. The input accepts while its register is
// empty or drains into a free or draining result register. Configuration
// writes take effect on the next edge and do not touch the governor state.
// ----------------------------------------------------------------------------
module gpu_dvfs_core_scaling_governor import gdcsg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [3:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] operation,
  input  logic [7:0] gpu_load,
  input  logic [7:0] pp_load,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] step,
  output logic [2:0] freq_level,
  output logic [3:0] cores_enabled,
  output logic       apply_request
);

  cfg_t       cfg;
  gov_state_t gov;
  gov_state_t gov_next;
  result_t    res_next;

  logic       s_valid;
  logic [1:0] s_op;
  logic [7:0] s_gpu;
  logic [7:0] s_pp;
  logic       advance;

  gdcsg_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gdcsg_core u_core (
    .cfg       (cfg),
    .cur       (gov),
    .operation (s_op),
    .gpu_load  (s_gpu),
    .pp_load   (s_pp),
    .nxt       (gov_next),
    .res       (res_next)
  );

  assign advance  = s_valid && (!out_valid || out_ready);
  assign in_ready = !s_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_op  <= operation;
      s_gpu <= gpu_load;
      s_pp  <= pp_load;
    end
  end

  // governor state
  always_ff @(posedge clk) begin
    if (rst) begin
      gov.cur_step     <= RstInitialStep;
      gov.applied_step <= RstInitialStep;
      gov.cores        <= RstTotalCores;
    end else if (advance) begin
      gov <= gov_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      step          <= res_next.step;
      freq_level    <= res_next.freq_level;
      cores_enabled <= res_next.cores_enabled;
      apply_request <= res_next.apply_request;
    end
  end

endmodule

// ===== design/gdcsg_checker.sv =====
// ----------------------------------------------------------------------------
// gdcsg_checker: port-level checks for the governor
// Result consistency and output-side flow control, bound to the top level.
// ----------------------------------------------------------------------------
module gdcsg_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] step,
  input logic [2:0] freq_level,
  input logic [3:0] cores_enabled,
  input logic       apply_request
);

  // no result may be pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // input only stalls when a result is waiting to be taken
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  // clock index must follow the fixed step table
  a_freq_map: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (step < 3'd5 && freq_level == step) ||
                  (step >= 3'd5 && freq_level == 3'd0))
    else $error("freq_level does not match step");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({step, freq_level, cores_enabled, apply_request}))
    else $error("stalled result changed");

endmodule

bind gpu_dvfs_core_scaling_governor gdcsg_checker u_gdcsg_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .step          (step),
  .freq_level    (freq_level),
  .cores_enabled (cores_enabled),
  .apply_request (apply_request)
);

// ===== tb/sv/gpu_dvfs_core_scaling_governor_test.sv =====
// ----------------------------------------------------------------------------
// gpu_dvfs_core_scaling_governor_test: self-checking bench for the governor
// Drives load samples, preheat and restart events under many register
// settings, predicts step, clock index, core count and apply flag per item,
// and checks every result in order with random idling on both sides.
// ----------------------------------------------------------------------------
module gpu_dvfs_core_scaling_governor_test;
  import gdcsg_pkg::*;

  localparam int         NumRegs    = 8;
  localparam int         CycleLimit = 400000;
  localparam int         Phases     = 14;
  localparam int         PhaseItems = 85;
  localparam logic [1:0] OpUnknown  = 2'd3;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [2:0] cfg_index;
  logic [3:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] operation;
  logic [7:0] gpu_load;
  logic [7:0] pp_load;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] step;
  logic [2:0] freq_level;
  logic [3:0] cores_enabled;
  logic       apply_request;

  gpu_dvfs_core_scaling_governor dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .gpu_load     (gpu_load),
    .pp_load      (pp_load),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .step         (step),
    .freq_level   (freq_level),
    .cores_enabled(cores_enabled),
    .apply_request(apply_request)
  );

  class governor_scoreboard;
    mode_t      mode;
    logic [2:0] min_step, max_step, turbo_step, fixed_step, init_step;
    logic [3:0] min_cores, total_cores;
    logic [2:0] cur_step, applied_step;
    logic [3:0] cores;
    result_t    pending_decisions[$];
    int         failures;

    function new();
      mode        = RstGovMode;
      min_step    = RstMinStep;
      max_step    = RstMaxStep;
      turbo_step  = RstTurboStep;
      fixed_step  = RstFixedStep;
      min_cores   = RstMinCores;
      total_cores = RstTotalCores;
      init_step   = RstInitialStep;
      cur_step     = RstInitialStep;
      applied_step = RstInitialStep;
      cores        = RstTotalCores;
      failures     = 0;
    endfunction

    // registers never touch the governor state
    function void set_reg(reg_idx_t idx, logic [3:0] v);
      case (idx)
        REG_GOV_MODE:     mode        = mode_t'(v[1:0]);
        REG_MIN_STEP:     min_step    = v[2:0];
        REG_MAX_STEP:     max_step    = v[2:0];
        REG_TURBO_STEP:   turbo_step  = v[2:0];
        REG_FIXED_STEP:   fixed_step  = v[2:0];
        REG_MIN_CORES:    min_cores   = v;
        REG_TOTAL_CORES:  total_cores = v;
        REG_INITIAL_STEP: init_step   = v[2:0];
        default: ;
      endcase
    endfunction

    // steps past the table read a row of zeros
    function logic [2:0] clk_index(logic [2:0] s);
      if (s >= TableEntries || s > 3'd4) return 3'd0;
      return s;
    endfunction

    function int down_limit(logic [2:0] s);
      if (s >= TableEntries) return 0;
      case (s)
        3'd1:    return 152;
        3'd2:    return 180;
        3'd3:    return 205;
        3'd4:    return 230;
        default: return 0;
      endcase
    endfunction

    function int up_limit(logic [2:0] s);
      if (s >= TableEntries) return 0;
      case (s)
        3'd0:    return 200;
        3'd1:    return 205;
        3'd2:    return 212;
        3'd3:    return 236;
        3'd4:    return 256;
        default: return 0;
      endcase
    endfunction

    function bit fill_cores();
      if (cores < total_cores) begin
        cores = total_cores;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit add_core();
      if (cores < total_cores) begin
        cores = cores + 4'd1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit drop_core();
      if (min_cores < cores) begin
        cores = cores - 4'd1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit freq_cores_sample(logic [7:0] g, logic [7:0] p);
      if (int'(g) >= up_limit(cur_step)) begin
        if (g < FastUpLimit && cur_step < max_step) cur_step = cur_step + 3'd1;
        else cur_step = max_step;
        if (p > PpAllCoresFs) void'(fill_cores());
        else void'(add_core());
      end else if (int'(g) < down_limit(cur_step) && cur_step > min_step) begin
        cur_step = cur_step - 3'd1;
      end else if (p < PpDropFs) begin
        void'(drop_core());
      end
      return cores != total_cores || clk_index(cur_step) != clk_index(applied_step);
    endfunction

    function bit core_only_sample(logic [7:0] p);
      cur_step = fixed_step;
      if (p > PpAllCores) return fill_cores();
      if (p > PpOneMore) return add_core();
      if (p > PpHold) return 1'b0;
      if (p > 8'd0) return drop_core();
      return 1'b0;
    endfunction

    function void accept_load(logic [1:0] op, logic [7:0] g, logic [7:0] p);
      result_t r;
      bit      go;
      go = 1'b0;
      case (op)
        OP_SAMPLE: begin
          if (mode == MODE_FREQ_CORES) go = freq_cores_sample(g, p);
          else if (mode == MODE_CORE_ONLY) go = core_only_sample(p);
        end
        OP_PREHEAT: go = fill_cores();
        OP_RESTART: begin
          cur_step = (mode == MODE_TURBO) ? turbo_step : max_step;
          void'(fill_cores());
          go = 1'b1;
        end
        default: ;
      endcase
      if (go && clk_index(cur_step) != clk_index(applied_step)) applied_step = cur_step;
      r.step          = cur_step;
      r.freq_level    = clk_index(cur_step);
      r.cores_enabled = cores;
      r.apply_request = go;
      pending_decisions.push_back(r);
    endfunction

    function void report(string what, result_t exp, result_t got);
      failures++;
      if (failures <= 10)
        $display("%s: exp step %0d idx %0d cores %0d apply %0d, got step %0d idx %0d cores %0d apply %0d",
                 what, exp.step, exp.freq_level, exp.cores_enabled, exp.apply_request,
                 got.step, got.freq_level, got.cores_enabled, got.apply_request);
    endfunction

    function void check_decision(result_t got);
      result_t exp;
      if (pending_decisions.size() == 0) begin
        report("unexpected result", got, got);
        return;
      end
      exp = pending_decisions.pop_front();
      if (got.step !== exp.step || got.freq_level !== exp.freq_level ||
          got.cores_enabled !== exp.cores_enabled || got.apply_request !== exp.apply_request)
        report("mismatch", exp, got);
    endfunction

    function int pending_count();
      return pending_decisions.size();
    endfunction
  endclass

  governor_scoreboard sb = new();

  logic [3:0] regval [NumRegs];
  int         rx_hold = 0;
  bit         quiet   = 1'b0;
  int         cycles  = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // pre-edge values of both channels decide each transfer
  always @(posedge clk) begin
    result_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.step          = step;
        got.freq_level    = freq_level;
        got.cores_enabled = cores_enabled;
        got.apply_request = apply_request;
        sb.check_decision(got);
      end
      if (in_valid && in_ready) sb.accept_load(operation, gpu_load, pp_load);
    end
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 9);
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] g, input logic [7:0] p);
    while (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    gpu_load  <= g;
    pp_load   <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // wait for the clock before polling, so the last transfer is already in the scoreboard
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  task automatic load_config();
    for (int i = 0; i < NumRegs; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= regval[i];
      sb.set_reg(reg_idx_t'(i), regval[i]);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic default_regs();
    regval[REG_GOV_MODE]     = 4'(RstGovMode);
    regval[REG_MIN_STEP]     = 4'(RstMinStep);
    regval[REG_MAX_STEP]     = 4'(RstMaxStep);
    regval[REG_TURBO_STEP]   = 4'(RstTurboStep);
    regval[REG_FIXED_STEP]   = 4'(RstFixedStep);
    regval[REG_MIN_CORES]    = RstMinCores;
    regval[REG_TOTAL_CORES]  = RstTotalCores;
    regval[REG_INITIAL_STEP] = 4'(RstInitialStep);
  endtask

  task automatic random_regs(input int ph);
    int m;
    m = $urandom_range(99);
    if (m < 40) regval[REG_GOV_MODE] = 4'(MODE_FREQ_CORES);
    else if (m < 70) regval[REG_GOV_MODE] = 4'(MODE_CORE_ONLY);
    else if (m < 85) regval[REG_GOV_MODE] = 4'(MODE_TURBO);
    else regval[REG_GOV_MODE] = 4'(MODE_DISABLED);
    regval[REG_MIN_STEP]     = 4'($urandom_range(3));
    regval[REG_MAX_STEP]     = 4'($urandom_range(99) < 80 ? $urandom_range(5, 3) : $urandom_range(7));
    regval[REG_TURBO_STEP]   = 4'($urandom_range(7));
    regval[REG_FIXED_STEP]   = 4'($urandom_range(7));
    regval[REG_MIN_CORES]    = 4'($urandom_range(99) < 80 ? $urandom_range(3, 1) : $urandom_range(15));
    regval[REG_TOTAL_CORES]  = 4'($urandom_range(99) < 80 ? $urandom_range(8, 4) : $urandom_range(15));
    regval[REG_INITIAL_STEP] = 4'($urandom_range(7));
    // extremes first: all-low, all-high, wide-open frequency range
    if (ph == 0) begin
      for (int i = 0; i < NumRegs; i++) regval[i] = 4'd0;
    end else if (ph == 1) begin
      regval[REG_GOV_MODE] = 4'(MODE_TURBO);
      for (int i = 1; i < NumRegs; i++) regval[i] = 4'd7;
      regval[REG_MIN_CORES]   = 4'd15;
      regval[REG_TOTAL_CORES] = 4'd15;
    end else if (ph == 2) begin
      regval[REG_GOV_MODE]     = 4'(MODE_FREQ_CORES);
      regval[REG_MIN_STEP]     = 4'd0;
      regval[REG_MAX_STEP]     = 4'd7;
      regval[REG_MIN_CORES]    = 4'd0;
      regval[REG_TOTAL_CORES]  = 4'd15;
    end
  endtask

  // half uniform, half clustered around a decision threshold
  function automatic logic [7:0] pick_load(input bit gpu_side);
    int base;
    int v;
    if ($urandom_range(1) == 0) return 8'($urandom_range(255));
    if (gpu_side) begin
      case ($urandom_range(6))
        0:       base = 152;
        1:       base = 180;
        2:       base = 200;
        3:       base = int'(FastUpLimit);
        4:       base = 212;
        5:       base = 230;
        default: base = 236;
      endcase
    end else begin
      case ($urandom_range(6))
        0:       base = 0;
        1:       base = int'(PpDropFs);
        2:       base = int'(PpHold);
        3:       base = int'(PpOneMore);
        4:       base = int'(PpAllCoresFs);
        5:       base = int'(PpAllCores);
        default: base = 255;
      endcase
    end
    v = base + int'($urandom_range(4)) - 2;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  initial begin
    int         r;
    logic [1:0] op;
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_GOV_MODE;
    cfg_data  <= 4'd0;
    in_valid  <= 1'b0;
    operation <= OP_SAMPLE;
    gpu_load  <= 8'd0;
    pp_load   <= 8'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // frequency-and-core mode from reset values
    send_item(OP_SAMPLE, 8'd0, 8'd0);
    send_item(OP_SAMPLE, 8'd255, 8'd255);
    send_item(OP_SAMPLE, 8'd204, 8'd76);
    send_item(OP_SAMPLE, 8'd205, 8'd77);
    send_item(OP_SAMPLE, 8'd0, 8'd76);
    send_item(OP_SAMPLE, 8'd199, 8'd206);
    send_item(OP_SAMPLE, 8'd200, 8'd0);
    send_item(OP_PREHEAT, 8'd0, 8'd0);
    send_item(OP_RESTART, 8'd255, 8'd255);
    send_item(OpUnknown, 8'd255, 8'd0);
    drain();

    // core-only, pixel load across each band edge
    default_regs();
    regval[REG_GOV_MODE]   = 4'(MODE_CORE_ONLY);
    regval[REG_FIXED_STEP] = 4'd5;
    load_config();
    send_item(OP_SAMPLE, 8'd0, 8'd0);
    send_item(OP_SAMPLE, 8'd0, 8'd1);
    send_item(OP_SAMPLE, 8'd0, 8'd102);
    send_item(OP_SAMPLE, 8'd0, 8'd103);
    send_item(OP_SAMPLE, 8'd0, 8'd128);
    send_item(OP_SAMPLE, 8'd0, 8'd129);
    send_item(OP_SAMPLE, 8'd0, 8'd230);
    send_item(OP_SAMPLE, 8'd0, 8'd231);
    send_item(OP_SAMPLE, 8'd255, 8'd255);
    drain();

    // turbo restart into a step beyond the table, then an ignored sample
    default_regs();
    regval[REG_GOV_MODE]   = 4'(MODE_TURBO);
    regval[REG_TURBO_STEP] = 4'd7;
    load_config();
    send_item(OP_RESTART, 8'd0, 8'd0);
    send_item(OP_SAMPLE, 8'd255, 8'd255);
    drain();

    default_regs();
    regval[REG_GOV_MODE] = 4'(MODE_DISABLED);
    load_config();
    send_item(OP_SAMPLE, 8'd0, 8'd0);
    send_item(OP_PREHEAT, 8'd255, 8'd255);
    drain();

    for (int ph = 0; ph < Phases; ph++) begin
      random_regs(ph);
      load_config();
      // long output stall while input keeps coming: block fills and stalls
      if (ph == 3) rx_hold = 80;
      quiet = (ph == 5);
      for (int n = 0; n < PhaseItems; n++) begin
        r = $urandom_range(99);
        if (r < 78) op = OP_SAMPLE;
        else if (r < 86) op = OP_PREHEAT;
        else if (r < 94) op = OP_RESTART;
        else op = OpUnknown;
        send_item(op, pick_load(1'b1), pick_load(1'b0));
      end
      drain();
      quiet = 1'b0;
    end

    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.pending_count() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
